// ===== rtl/ipa_pkg.sv =====
package ipa_pkg;

   localparam int DEFAULT_POOL_SIZE = 256;

   localparam int TYPE_W   = 2;
   localparam int AMT_W    = 9;
   localparam int DATA_W   = 8;
   localparam int STATUS_W = 2;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_GENERATE = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_ALLOCATE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RELEASE  = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

   typedef struct packed {
      logic capture;       // latch request fields, clear working result
      logic gen_setup;     // compute clipped generate count
      logic gen_step;      // write one fresh index into the idle FIFO
      logic refill_start;  // rewind idle head before refill
      logic refill_step;   // pop rest stack top into refill pipe
      logic release_exec;  // push released index
      logic alloc_empty;   // nothing to hand out
      logic alloc_take;    // pop idle head
      logic load_rsp;      // move working result to response register
   } ipa_cmd_type;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic              idle_empty;
      logic              rest_empty;
      logic              gen_done;
      logic              refill_pend;
   } ipa_stat_type;

endpackage

// ===== rtl/ipa_ctrl.sv =====
module ipa_ctrl
   import ipa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  ipa_stat_type stat,
   output ipa_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_GEN,
      S_REFILL,
      S_ALLOC_RD,
      S_ALLOC_WAIT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.req_type)
               REQ_GENERATE: begin
                  cmd.gen_setup = 1'b1;
                  state_in      = S_GEN;
               end
               REQ_ALLOCATE: begin
                  if (stat.idle_empty && !stat.rest_empty) begin
                     cmd.refill_start = 1'b1;
                     state_in         = S_REFILL;
                  end else begin
                     state_in = S_ALLOC_RD;
                  end
               end
               REQ_RELEASE: begin
                  cmd.release_exec = 1'b1;
                  state_in         = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_GEN: begin
            if (stat.gen_done) begin
               state_in = S_DONE;
            end else begin
               cmd.gen_step = 1'b1;
            end
         end
         S_REFILL: begin
            // last write drains in the cycle after the last stack read
            if (stat.rest_empty && !stat.refill_pend) begin
               state_in = S_ALLOC_RD;
            end else begin
               cmd.refill_step = 1'b1;
            end
         end
         S_ALLOC_RD: begin
            if (stat.idle_empty) begin
               cmd.alloc_empty = 1'b1;
               state_in        = S_DONE;
            end else begin
               state_in = S_ALLOC_WAIT;
            end
         end
         S_ALLOC_WAIT: begin
            cmd.alloc_take = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/ipa_datapath.sv =====
module ipa_datapath
   import ipa_pkg::*;
#(
   parameter int POOL_SIZE = DEFAULT_POOL_SIZE
) (
   input  logic                clock,
   input  logic                reset,
   input  ipa_cmd_type         cmd,
   output ipa_stat_type        stat,
   input  logic [TYPE_W-1:0]   req_type,
   input  logic [AMT_W-1:0]    req_amount,
   input  logic [DATA_W-1:0]   req_index,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [DATA_W-1:0]   rsp_index_res
);

   localparam int ADDR_W = $clog2(POOL_SIZE);
   localparam int CNT_W  = $clog2(POOL_SIZE + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int GEN_W  = (CNT_W > AMT_W) ? CNT_W : AMT_W;

   localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(POOL_SIZE);
   localparam logic [SUM_W-1:0]  POOL_SUM  = SUM_W'(POOL_SIZE);
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(POOL_SIZE - 1);

   logic [DATA_W-1:0] idle_mem [POOL_SIZE];
   logic [DATA_W-1:0] rest_mem [POOL_SIZE];

   // captured request
   logic [TYPE_W-1:0]   type_ff, type_in;
   logic [AMT_W-1:0]    amount_ff, amount_in;
   logic [DATA_W-1:0]   index_ff, index_in;

   // pool state
   logic [ADDR_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]    idle_cnt_ff, idle_cnt_in;
   logic [CNT_W-1:0]    rest_cnt_ff, rest_cnt_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [CNT_W-1:0]    gen_left_ff, gen_left_in;
   logic                pend_ff, pend_in;

   // working and delivered result
   logic [STATUS_W-1:0] res_st_ff, res_st_in;
   logic [DATA_W-1:0]   res_idx_ff, res_idx_in;
   logic [STATUS_W-1:0] rsp_st_ff, rsp_st_in;
   logic [DATA_W-1:0]   rsp_idx_ff, rsp_idx_in;

   logic [DATA_W-1:0]   idle_rdata_ff, rest_rdata_ff;

   logic                idle_we, rest_we;
   logic [ADDR_W-1:0]   idle_waddr, rest_waddr;
   logic [DATA_W-1:0]   idle_wdata, rest_wdata;

   logic [SUM_W-1:0]    tail_sum;
   logic [ADDR_W-1:0]   tail_slot;
   logic [CNT_W-1:0]    rest_top;
   logic [GEN_W-1:0]    want, room_tot, room_fifo, n_part, n_gen;

   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(idle_cnt_ff);
   assign tail_slot = (tail_sum >= POOL_SUM) ? ADDR_W'(tail_sum - POOL_SUM)
                                             : ADDR_W'(tail_sum);
   assign rest_top  = rest_cnt_ff - CNT_W'(1);

   // clipped generate count
   assign want      = (amount_ff == '0) ? GEN_W'(1) : GEN_W'(amount_ff);
   assign room_tot  = GEN_W'(POOL_CNT - total_ff);
   assign room_fifo = GEN_W'(POOL_CNT - idle_cnt_ff);
   assign n_part    = (want < room_tot) ? want : room_tot;
   assign n_gen     = (n_part < room_fifo) ? n_part : room_fifo;

   assign stat.req_type    = type_ff;
   assign stat.idle_empty  = (idle_cnt_ff == '0);
   assign stat.rest_empty  = (rest_cnt_ff == '0);
   assign stat.gen_done    = (gen_left_ff == '0);
   assign stat.refill_pend = pend_ff;

   assign rsp_status    = rsp_st_ff;
   assign rsp_index_res = rsp_idx_ff;

   always_comb begin
      type_in     = type_ff;
      amount_in   = amount_ff;
      index_in    = index_ff;
      head_in     = head_ff;
      idle_cnt_in = idle_cnt_ff;
      rest_cnt_in = rest_cnt_ff;
      total_in    = total_ff;
      gen_left_in = gen_left_ff;
      pend_in     = 1'b0;
      res_st_in   = res_st_ff;
      res_idx_in  = res_idx_ff;
      rsp_st_in   = rsp_st_ff;
      rsp_idx_in  = rsp_idx_ff;
      idle_we     = 1'b0;
      idle_waddr  = tail_slot;
      idle_wdata  = DATA_W'(total_ff);
      rest_we     = 1'b0;
      rest_waddr  = rest_cnt_ff[ADDR_W-1:0];
      rest_wdata  = index_ff;

      if (cmd.capture) begin
         type_in    = req_type;
         amount_in  = req_amount;
         index_in   = req_index;
         res_st_in  = ST_OK;
         res_idx_in = '0;
      end

      if (cmd.gen_setup) begin
         gen_left_in = CNT_W'(n_gen);
         if (n_gen < want) begin
            res_st_in = ST_OVER;
         end
         if (n_gen != '0) begin
            res_idx_in = DATA_W'(total_ff);
         end
      end

      if (cmd.gen_step) begin
         idle_we     = 1'b1;
         total_in    = total_ff + CNT_W'(1);
         idle_cnt_in = idle_cnt_ff + CNT_W'(1);
         gen_left_in = gen_left_ff - CNT_W'(1);
      end

      if (cmd.refill_start) begin
         head_in = '0;
      end

      if (cmd.refill_step && (rest_cnt_ff != '0)) begin
         rest_cnt_in = rest_top;
         pend_in     = 1'b1;
      end

      // stack entry read last cycle lands at the FIFO fill position
      if (pend_ff) begin
         idle_we     = 1'b1;
         idle_waddr  = idle_cnt_ff[ADDR_W-1:0];
         idle_wdata  = rest_rdata_ff;
         idle_cnt_in = idle_cnt_ff + CNT_W'(1);
      end

      if (cmd.release_exec) begin
         if (rest_cnt_ff == POOL_CNT) begin
            res_st_in = ST_OVER;
         end else begin
            rest_we     = 1'b1;
            rest_cnt_in = rest_cnt_ff + CNT_W'(1);
         end
      end

      if (cmd.alloc_empty) begin
         res_st_in = ST_EMPTY;
      end

      if (cmd.alloc_take) begin
         res_idx_in  = idle_rdata_ff;
         head_in     = (head_ff == LAST_SLOT) ? '0 : head_ff + ADDR_W'(1);
         idle_cnt_in = idle_cnt_ff - CNT_W'(1);
      end

      if (cmd.load_rsp) begin
         rsp_st_in  = res_st_ff;
         rsp_idx_in = res_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         idle_cnt_ff <= '0;
         rest_cnt_ff <= '0;
         total_ff    <= '0;
         gen_left_ff <= '0;
         pend_ff     <= 1'b0;
      end else begin
         head_ff     <= head_in;
         idle_cnt_ff <= idle_cnt_in;
         rest_cnt_ff <= rest_cnt_in;
         total_ff    <= total_in;
         gen_left_ff <= gen_left_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff    <= type_in;
      amount_ff  <= amount_in;
      index_ff   <= index_in;
      res_st_ff  <= res_st_in;
      res_idx_ff <= res_idx_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_idx_ff <= rsp_idx_in;
   end

   always_ff @(posedge clock) begin
      if (idle_we) begin
         idle_mem[idle_waddr] <= idle_wdata;
      end
      idle_rdata_ff <= idle_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (rest_we) begin
         rest_mem[rest_waddr] <= rest_wdata;
      end
      rest_rdata_ff <= rest_mem[rest_top[ADDR_W-1:0]];
   end

endmodule

// ===== rtl/index_pool_allocator.sv =====
// One request in flight; from accept to response valid: generate sets up, then writes n
//   indices (n = indices written, one per cycle); allocate reads and takes the head,
//   first refilling an empty FIFO from the stack (registered read); release and others
//   respond directly. Next request is taken at earliest in the cycle rsp_valid rises;
//   a response not yet taken holds the following one in its last cycle.
// Sync active-high reset clears counters and control; index memories are not cleared.
module index_pool_allocator
   import ipa_pkg::*;
#(
   parameter int POOL_SIZE = DEFAULT_POOL_SIZE
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [TYPE_W-1:0]   req_type,
   input  logic [AMT_W-1:0]    req_amount,
   input  logic [DATA_W-1:0]   req_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [DATA_W-1:0]   rsp_index_res
);

   ipa_cmd_type  cmd;
   ipa_stat_type stat;

   ipa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ipa_datapath #(
      .POOL_SIZE (POOL_SIZE)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_type      (req_type),
      .req_amount    (req_amount),
      .req_index     (req_index),
      .rsp_status    (rsp_status),
      .rsp_index_res (rsp_index_res)
   );

endmodule

// ===== sim/tb_index_pool_allocator.sv =====
module tb_index_pool_allocator;
   import ipa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL = DEFAULT_POOL_SIZE;
   localparam int RANDOM_ITEMS = 1530;
   localparam int SCRIPT_LEN = 17;
   localparam int OWED_DEPTH = 64;
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   index_res;
   } pool_rsp_type;

   typedef struct {
      logic [TYPE_W-1:0] kind;
      logic [AMT_W-1:0]  amount;
      logic [DATA_W-1:0] index;
      bit                typed;
      pool_rsp_type      rsp;
   } script_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [TYPE_W-1:0]   req_type;
   logic [AMT_W-1:0]    req_amount;
   logic [DATA_W-1:0]   req_index;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [DATA_W-1:0]   rsp_index_res;

   // shadow copy of the pool
   int unsigned fifo_slot [POOL];
   int unsigned fifo_head;
   int unsigned fifo_count;
   int unsigned stack_val [POOL];
   int unsigned stack_count;
   int unsigned issued;

   // expected responses, in request order
   pool_rsp_type rsp_owed [OWED_DEPTH];
   int unsigned  owed_wr = 0;
   int unsigned  owed_rd = 0;
   int           errors = 0;
   bit           send_steady = 1'b0;

   index_pool_allocator dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_amount   (req_amount),
      .req_index    (req_index),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_index_res(rsp_index_res)
   );

   always #10 clock = ~clock;

   task automatic pool_predict(input logic [TYPE_W-1:0] kind, input logic [AMT_W-1:0] amount,
                               input logic [DATA_W-1:0] index, output pool_rsp_type rsp);
      int unsigned want;
      int unsigned n;
      rsp = '0;
      rsp.status = ST_OK;
      case (kind)
         REQ_GENERATE: begin
            want = (amount == 0) ? 1 : amount;
            n = want;
            if (n > POOL - issued) n = POOL - issued;
            if (n > POOL - fifo_count) n = POOL - fifo_count;
            if (n < want) rsp.status = ST_OVER;
            if (n > 0) rsp.index_res = DATA_W'(issued);
            for (int k = 0; k < n; k++) begin
               fifo_slot[(fifo_head + fifo_count) % POOL] = issued + k;
               fifo_count++;
            end
            issued += n;
         end
         REQ_ALLOCATE: begin
            if (fifo_count == 0) begin
               // refill from the released stack, top entry first
               fifo_head = 0;
               for (int k = 0; k < stack_count; k++)
                  fifo_slot[k] = stack_val[stack_count - 1 - k];
               fifo_count = stack_count;
               stack_count = 0;
            end
            if (fifo_count == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               rsp.index_res = DATA_W'(fifo_slot[fifo_head]);
               fifo_head = (fifo_head + 1) % POOL;
               fifo_count--;
            end
         end
         REQ_RELEASE: begin
            if (stack_count >= POOL) begin
               rsp.status = ST_OVER;
            end else begin
               stack_val[stack_count] = index;
               stack_count++;
            end
         end
         default: ;
      endcase
   endtask

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [AMT_W-1:0] gen_amount();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return AMT_W'(256);
      if (r < 70) return AMT_W'($urandom_range(0, 4));
      return AMT_W'($urandom_range(5, 40));
   endfunction

   function automatic logic [TYPE_W-1:0] pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return REQ_ALLOCATE;
      if (r < 90) return REQ_RELEASE;
      if (r < 96) return REQ_GENERATE;
      return REQ_UNUSED;
   endfunction

   function automatic script_row_type script_row(input logic [TYPE_W-1:0] kind,
                                                 input int amount, input int index,
                                                 input bit typed,
                                                 input logic [STATUS_W-1:0] status,
                                                 input int index_res);
      script_row_type row;
      row.kind          = kind;
      row.amount        = AMT_W'(amount);
      row.index         = DATA_W'(index);
      row.typed         = typed;
      row.rsp.status    = status;
      row.rsp.index_res = DATA_W'(index_res);
      return row;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic offer_request(input logic [TYPE_W-1:0] kind, input logic [AMT_W-1:0] amount,
                                input logic [DATA_W-1:0] index, input bit typed,
                                input pool_rsp_type typed_rsp);
      pool_rsp_type guess;
      int           gap;
      gap = send_steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_type   <= kind;
      req_amount <= amount;
      req_index  <= index;
      do @(posedge clock); while (!req_ready);
      pool_predict(kind, amount, index, guess);
      rsp_owed[owed_wr % OWED_DEPTH] = typed ? typed_rsp : guess;
      owed_wr++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      pool_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_wr == owed_rd) begin
            $display("%0t: unexpected response: expected none, got status %0d index %0d",
                     $time, rsp_status, rsp_index_res);
            errors++;
         end else begin
            want = rsp_owed[owed_rd % OWED_DEPTH];
            owed_rd++;
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, got %0d",
                        $time, want.status, rsp_status);
               errors++;
            end
            if (rsp_index_res !== want.index_res) begin
               $display("%0t: index_res mismatch: expected %0d, got %0d",
                        $time, want.index_res, rsp_index_res);
               errors++;
            end
         end
      end
   end

   // response side; one long hold-off lets the block back up into the request side
   initial begin : rsp_side
      int stall;
      int taken;
      bit steady;
      taken = 0;
      steady = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) steady = ~steady;
         if (taken == 300) stall = 400;
         else stall = steady ? 0 : idle_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      script_row_type script [SCRIPT_LEN];
      logic [TYPE_W-1:0] kind;
      int r;
      int len;
      int sent;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_type   = REQ_GENERATE;
      req_amount = '0;
      req_index  = '0;
      fifo_head   = 0;
      fifo_count  = 0;
      stack_count = 0;
      issued      = 0;

      script[0]  = script_row(REQ_ALLOCATE,   0,   0, 1, ST_EMPTY, 0);
      script[1]  = script_row(REQ_RELEASE,    0,   0, 1, ST_OK,    0);
      script[2]  = script_row(REQ_RELEASE,  256, 255, 1, ST_OK,    0);
      script[3]  = script_row(REQ_UNUSED,   256, 255, 1, ST_OK,    0);
      script[4]  = script_row(REQ_ALLOCATE,   0,   0, 0, ST_OK,    0);
      script[5]  = script_row(REQ_ALLOCATE,   0,   0, 0, ST_OK,    0);
      script[6]  = script_row(REQ_ALLOCATE,   0,   0, 1, ST_EMPTY, 0);
      script[7]  = script_row(REQ_GENERATE,   0,   0, 1, ST_OK,    0);
      script[8]  = script_row(REQ_GENERATE,   1,  85, 0, ST_OK,    0);
      script[9]  = script_row(REQ_GENERATE,   3, 170, 0, ST_OK,    0);
      script[10] = script_row(REQ_ALLOCATE, 255,   0, 0, ST_OK,    0);
      script[11] = script_row(REQ_RELEASE,    0, 170, 0, ST_OK,    0);
      script[12] = script_row(REQ_RELEASE,    0,  85, 0, ST_OK,    0);
      script[13] = script_row(REQ_GENERATE, 256,   0, 0, ST_OK,    0);
      script[14] = script_row(REQ_GENERATE,   0,   0, 1, ST_OVER,  0);
      script[15] = script_row(REQ_ALLOCATE,   0,   0, 0, ST_OK,    0);
      script[16] = script_row(REQ_UNUSED,     0,   0, 1, ST_OK,    0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i])
         offer_request(script[i].kind, script[i].amount, script[i].index,
                       script[i].typed, script[i].rsp);

      // bursts of one request type drain and fill the stores; mixed runs in between
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         send_steady = ($urandom_range(0, 4) == 0);
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
         for (int k = 0; k < len && sent < RANDOM_ITEMS; k++) begin
            if (r < 25) kind = REQ_RELEASE;
            else if (r < 50) kind = REQ_ALLOCATE;
            else if (r < 55) kind = REQ_GENERATE;
            else kind = pick_kind();
            offer_request(kind, gen_amount(), DATA_W'($urandom_range(0, 255)), 1'b0, '0);
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (owed_wr != owed_rd) @(posedge clock);
      repeat (300) @(posedge clock);

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ipa_pkg.sv
rtl/ipa_ctrl.sv
rtl/ipa_datapath.sv
rtl/index_pool_allocator.sv
sim/tb_index_pool_allocator.sv
